@@ design/tle_pkg.sv @@
// Shared types and constants of the terminal line editor.
package tle_pkg;

	localparam int LINE_CAP   = 32;
	localparam int HIST_DEPTH = 5;

	localparam int LEN_W  = $clog2(LINE_CAP);
	localparam int IDX_W  = LEN_W;
	localparam int SLOT_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int FILL_W = $clog2(HIST_DEPTH + 1);

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_DEL  = 8'h7F;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_LBRK = 8'h5B;
	localparam logic [7:0] CH_UP   = 8'h41;
	localparam logic [7:0] CH_DOWN = 8'h42;
	localparam logic [7:0] CH_K    = 8'h4B;

	localparam logic [1:0] DEST_TERM = 2'd0;
	localparam logic [1:0] DEST_CMD  = 2'd1;
	localparam logic [1:0] DEST_END  = 2'd2;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_ERASE,
		OP_ENTER,
		OP_OLDER,
		OP_NEWER
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] b;
	} cmd_t;

endpackage

@@ design/tle_rx_if.sv @@
// Received byte channel.
interface tle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

@@ design/tle_res_if.sv @@
// Result channel: terminal echo, command line bytes and end marker.
interface tle_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] dest;
	logic [7:0] data;
	logic       last;

	modport source(output valid, output dest, output data, output last, input ready);
	modport sink(input valid, input dest, input data, input last, output ready);
endinterface

@@ design/tle_front.sv @@
// Front end: escape sequence parsing and byte classification into editor commands.
module tle_front
	import tle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tle_rx_if.sink     rx,
	output logic       cmd_vld,
	input  logic       cmd_rdy,
	output cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_TEXT,
		ST_ESC1,
		ST_ESC2
	} state_t;

	state_t state_q;
	logic   lbrk_q;
	logic   gen;
	logic   beat;

	assign rx.ready = cmd_rdy;
	assign beat     = rx.valid && cmd_rdy;

	always_comb begin
		gen    = 1'b0;
		cmd.b  = rx.rx_byte;
		cmd.op = OP_CHAR;
		case (state_q)
			ST_TEXT: begin
				if (rx.rx_byte == CH_ESC) begin
					gen = 1'b0;
				end else if (rx.rx_byte == CH_CR || rx.rx_byte == CH_LF) begin
					gen    = 1'b1;
					cmd.op = OP_ENTER;
				end else if (rx.rx_byte == CH_BS || rx.rx_byte == CH_DEL) begin
					gen    = 1'b1;
					cmd.op = OP_ERASE;
				end else begin
					gen    = 1'b1;
					cmd.op = OP_CHAR;
				end
			end
			ST_ESC2: begin
				if (lbrk_q && rx.rx_byte == CH_UP) begin
					gen    = 1'b1;
					cmd.op = OP_OLDER;
				end else if (lbrk_q && rx.rx_byte == CH_DOWN) begin
					gen    = 1'b1;
					cmd.op = OP_NEWER;
				end
			end
			default: gen = 1'b0;
		endcase
	end

	assign cmd_vld = rx.valid && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TEXT;
			lbrk_q  <= 1'b0;
		end else if (beat) begin
			case (state_q)
				ST_TEXT: begin
					if (rx.rx_byte == CH_ESC) state_q <= ST_ESC1;
				end
				ST_ESC1: begin
					lbrk_q  <= (rx.rx_byte == CH_LBRK);
					state_q <= ST_ESC2;
				end
				ST_ESC2: begin
					lbrk_q  <= 1'b0;
					state_q <= ST_TEXT;
				end
				default: state_q <= ST_TEXT;
			endcase
		end
	end

endmodule

@@ design/tle_cmd_fifo.sv @@
// Two-entry command queue between front end and back end.
module tle_cmd_fifo
	import tle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_vld,
	output logic push_rdy,
	input  cmd_t push_cmd,
	output logic pop_vld,
	input  logic pop_rdy,
	output cmd_t pop_cmd
);

	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_rdy = (cnt_q != 2'd2);
	assign pop_vld  = (cnt_q != 2'd0);
	assign pop_cmd  = ent_q[rptr_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop)  rptr_q <= ~rptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/tle_back.sv @@
// Back end: edit line, history ring and result sequencing.
module tle_back
	import tle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_vld,
	output logic      cmd_rdy,
	input  cmd_t      cmd,
	tle_res_if.source res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRE,
		ST_STREAM,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PRE_ECHO,
		PRE_ERASE,
		PRE_CRLF,
		PRE_CLEAR
	} pre_t;

	function automatic logic [7:0] pre_byte(pre_t kind, logic [1:0] k, logic [7:0] b);
		logic [7:0] r;
		r = b;
		case (kind)
			PRE_ECHO:  r = b;
			PRE_ERASE: r = (k == 2'd1) ? CH_SP : CH_BS;
			PRE_CRLF:  r = (k == 2'd0) ? CH_CR : CH_LF;
			PRE_CLEAR: begin
				case (k)
					2'd0:    r = CH_CR;
					2'd1:    r = CH_ESC;
					2'd2:    r = CH_LBRK;
					default: r = CH_K;
				endcase
			end
			default:   r = b;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pre_last(pre_t kind);
		logic [1:0] r;
		case (kind)
			PRE_ECHO:  r = 2'd0;
			PRE_ERASE: r = 2'd2;
			PRE_CRLF:  r = 2'd1;
			PRE_CLEAR: r = 2'd3;
			default:   r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [SLOT_W-1:0] wrap(logic [FILL_W:0] v);
		logic [FILL_W:0] r;
		r = (v >= (FILL_W+1)'(HIST_DEPTH)) ? v - (FILL_W+1)'(HIST_DEPTH) : v;
		return r[SLOT_W-1:0];
	endfunction

	// control state
	state_t            state_q;
	pre_t              pre_kind_q;
	logic [1:0]        pre_k_q;
	logic [7:0]        byte_q;
	logic              enter_q;
	logic              wr_hist_q;
	logic              wr_edit_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic [SLOT_W-1:0] wr_slot_q;
	logic [LEN_W-1:0]  edit_len_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] oldest_q;
	logic              rec_on_q;
	logic [SLOT_W-1:0] rec_pos_q;
	logic [LEN_W-1:0]  hist_len_q [HIST_DEPTH];
	logic              out_vld_q;
	logic [1:0]        out_dest_q;
	logic [7:0]        out_data_q;
	logic              out_last_q;

	// storage
	logic [7:0]        edit_mem [LINE_CAP];
	logic [7:0]        hist_mem [HIST_DEPTH][LINE_CAP];
	logic [7:0]        edit_rd_s1;
	logic [7:0]        hist_rd_s1;

	logic              pop;
	logic              emit;
	logic              pre_done;
	logic              strm_done;
	logic [IDX_W-1:0]  raddr;
	logic              edit_we;
	logic [IDX_W-1:0]  edit_waddr;
	logic [7:0]        edit_wdata;
	logic              hist_we;

	logic              hist_full;
	logic [FILL_W-1:0] fill_m1;
	logic [SLOT_W-1:0] older_pos;
	logic              newer_load;
	logic [SLOT_W-1:0] rp_new;
	logic [FILL_W-1:0] logical;
	logic [SLOT_W-1:0] phys;
	logic [SLOT_W-1:0] push_slot;
	logic [1:0]        nxt_dest;
	logic [7:0]        nxt_data;
	logic              nxt_last;

	assign cmd_rdy = (state_q == ST_IDLE);
	assign pop     = cmd_vld && cmd_rdy;
	assign emit    = (state_q != ST_IDLE) && (!out_vld_q || res.ready);

	assign res.valid = out_vld_q;
	assign res.dest  = out_dest_q;
	assign res.data  = out_data_q;
	assign res.last  = out_last_q;

	// history ring addressing
	assign hist_full  = (fill_q == FILL_W'(HIST_DEPTH));
	assign fill_m1    = fill_q - 1'b1;
	assign older_pos  = !rec_on_q ? '0 :
		((FILL_W'(rec_pos_q) < fill_m1) ? rec_pos_q + 1'b1 : rec_pos_q);
	assign newer_load = rec_on_q && (rec_pos_q != '0);
	assign rp_new     = (cmd.op == OP_OLDER) ? older_pos : rec_pos_q - 1'b1;
	assign logical    = fill_m1 - FILL_W'(rp_new);
	assign phys       = wrap((FILL_W+1)'(oldest_q) + (FILL_W+1)'(logical));
	assign push_slot  = hist_full ? oldest_q :
		wrap((FILL_W+1)'(oldest_q) + (FILL_W+1)'(fill_q));

	assign pre_done  = (pre_k_q == pre_last(pre_kind_q));
	assign strm_done = (idx_q == cnt_q - 1'b1);

	always_comb begin
		nxt_dest = DEST_TERM;
		nxt_data = 8'h00;
		nxt_last = 1'b0;
		case (state_q)
			ST_PRE: begin
				nxt_data = pre_byte(pre_kind_q, pre_k_q, byte_q);
				nxt_last = pre_done && (cnt_q == '0) && !enter_q;
			end
			ST_STREAM: begin
				nxt_dest = enter_q ? DEST_CMD : DEST_TERM;
				nxt_data = enter_q ? edit_rd_s1 : hist_rd_s1;
				nxt_last = strm_done && !enter_q;
			end
			ST_FIN: begin
				nxt_dest = DEST_END;
				nxt_last = 1'b1;
			end
			default: nxt_last = 1'b0;
		endcase
	end

	// read address runs one ahead while streaming so each cycle yields a byte unless res stalls
	assign raddr = (state_q == ST_STREAM && emit) ? idx_q + 1'b1 : idx_q;

	always_comb begin
		edit_we    = 1'b0;
		edit_waddr = idx_q;
		edit_wdata = hist_rd_s1;
		if (pop && cmd.op == OP_CHAR && edit_len_q < LEN_W'(LINE_CAP - 1)) begin
			edit_we    = 1'b1;
			edit_waddr = edit_len_q;
			edit_wdata = cmd.b;
		end else if (state_q == ST_STREAM && emit && wr_edit_q) begin
			edit_we = 1'b1;
		end
	end

	assign hist_we = (state_q == ST_STREAM) && emit && wr_hist_q;

	always_ff @(posedge clk) begin
		if (edit_we) edit_mem[edit_waddr] <= edit_wdata;
		if (hist_we) hist_mem[wr_slot_q][idx_q] <= edit_rd_s1;
		edit_rd_s1 <= edit_mem[raddr];
		hist_rd_s1 <= hist_mem[rd_slot_q][raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pre_kind_q <= PRE_ECHO;
			pre_k_q    <= 2'd0;
			byte_q     <= 8'h00;
			enter_q    <= 1'b0;
			wr_hist_q  <= 1'b0;
			wr_edit_q  <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
			rd_slot_q  <= '0;
			wr_slot_q  <= '0;
			edit_len_q <= '0;
			fill_q     <= '0;
			oldest_q   <= '0;
			rec_on_q   <= 1'b0;
			rec_pos_q  <= '0;
			hist_len_q <= '{default: '0};
			out_vld_q  <= 1'b0;
			out_dest_q <= DEST_TERM;
			out_data_q <= 8'h00;
			out_last_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q  <= 1'b1;
				out_dest_q <= nxt_dest;
				out_data_q <= nxt_data;
				out_last_q <= nxt_last;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						pre_k_q   <= 2'd0;
						idx_q     <= '0;
						byte_q    <= cmd.b;
						enter_q   <= 1'b0;
						wr_hist_q <= 1'b0;
						wr_edit_q <= 1'b0;
						cnt_q     <= '0;
						case (cmd.op)
							OP_CHAR: begin
								if (edit_len_q < LEN_W'(LINE_CAP - 1)) begin
									edit_len_q <= edit_len_q + 1'b1;
									pre_kind_q <= PRE_ECHO;
									state_q    <= ST_PRE;
								end
							end
							OP_ERASE: begin
								if (edit_len_q != '0) begin
									edit_len_q <= edit_len_q - 1'b1;
									pre_kind_q <= PRE_ERASE;
									state_q    <= ST_PRE;
								end
							end
							OP_ENTER: begin
								pre_kind_q <= PRE_CRLF;
								enter_q    <= 1'b1;
								cnt_q      <= edit_len_q;
								wr_slot_q  <= push_slot;
								rec_on_q   <= 1'b0;
								edit_len_q <= '0;
								state_q    <= ST_PRE;
								if (edit_len_q != '0) begin
									wr_hist_q             <= 1'b1;
									hist_len_q[push_slot] <= edit_len_q;
									if (hist_full) oldest_q <= wrap((FILL_W+1)'(oldest_q) + 1'b1);
									else fill_q <= fill_q + 1'b1;
								end
							end
							OP_OLDER, OP_NEWER: begin
								if (fill_q != '0) begin
									pre_kind_q <= PRE_CLEAR;
									state_q    <= ST_PRE;
									if (cmd.op == OP_OLDER || newer_load) begin
										rec_on_q   <= 1'b1;
										rec_pos_q  <= rp_new;
										rd_slot_q  <= phys;
										cnt_q      <= hist_len_q[phys];
										edit_len_q <= hist_len_q[phys];
										wr_edit_q  <= 1'b1;
									end else begin
										rec_on_q   <= 1'b0;
										edit_len_q <= '0;
									end
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PRE: begin
					if (emit) begin
						if (!pre_done) pre_k_q <= pre_k_q + 2'd1;
						else if (cnt_q != '0) state_q <= ST_STREAM;
						else if (enter_q) state_q <= ST_FIN;
						else state_q <= ST_IDLE;
					end
				end
				ST_STREAM: begin
					if (emit) begin
						idx_q <= idx_q + 1'b1;
						if (strm_done) state_q <= enter_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (emit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ design/terminal_line_editor_history.sv @@
// Top level of the terminal line editor with command history.
//
//  channel | dir | beat payload           | meaning
//  rx      | in  | rx_byte[7:0]           | one byte received from the terminal
//  res     | out | dest[1:0] data[7:0] last | echo byte, command byte or end marker
//
// Each result beat takes one cycle when res is not stalled. The back end takes a
// command only when idle, then sends CR ESC [ K and the n bytes for a recall, CR LF,
// n bytes and an end marker for an enter, the echo byte, or BS SP BS for an erase.
// The front end classifies one byte per cycle into a two-entry command queue;
// rx stalls only while that queue is full. A stalled res holds the back end.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
module terminal_line_editor_history
	import tle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tle_rx_if.sink    rx,
	tle_res_if.source res
);

	logic f_vld;
	logic f_rdy;
	cmd_t f_cmd;
	logic b_vld;
	logic b_rdy;
	cmd_t b_cmd;

	tle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.cmd_vld (f_vld),
		.cmd_rdy (f_rdy),
		.cmd     (f_cmd)
	);

	tle_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_vld (f_vld),
		.push_rdy (f_rdy),
		.push_cmd (f_cmd),
		.pop_vld  (b_vld),
		.pop_rdy  (b_rdy),
		.pop_cmd  (b_cmd)
	);

	tle_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (b_vld),
		.cmd_rdy (b_rdy),
		.cmd     (b_cmd),
		.res     (res)
	);

endmodule
